@@ src/ptfq_pkg.sv @@
// Package for the priority transmit frame queue.
// Holds the sequencer state type, event and link answer codes, and the scan candidate type.
// No dependencies.
package ptfq_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_EVICT,
    ST_EVICT_END,
    ST_STORE,
    ST_PICK,
    ST_PICK_END,
    ST_DONE
  } ptfq_state_t;

  typedef enum logic [1:0] {
    CMD_ENQUEUE  = 2'd0,
    CMD_TX_DONE  = 2'd1,
    CMD_LINK_ERR = 2'd2
  } ptfq_cmd_t;

  localparam logic [1:0] LINK_OK   = 2'd0;
  localparam logic [1:0] LINK_BUSY = 2'd1;

  localparam int AGE_BITS = 32;
  localparam int CNT_BITS = 32;

  // One slot as seen by the shared compare unit.
  typedef struct packed {
    logic                valid;
    logic                urgent;
    logic [AGE_BITS-1:0] age;
  } ptfq_cand_t;

endpackage

@@ src/priority_tx_frame_queue.sv @@
// An ignored or refused event goes straight to the result strobe. A transmit complete or link
// error scans for a frame to start; an enqueue with room stores, then scans if none is active;
// an enqueue into a full queue scans for a victim first. One transaction at a time; the next is
// taken in the cycle after the strobe. The compare unit visits one slot per cycle in each scan.
// Reset (synchronous, active low) empties all slots, clears the counters and the age sequence.
// Depends on ptfq_pkg and ptfq_age_cmp.
module priority_tx_frame_queue import ptfq_pkg::*; #(
  parameter int SLOTS           = 4,
  parameter int MAX_FRAME_BYTES = 64,
  parameter int REF_BITS        = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_cmd,
  input  logic [REF_BITS-1:0] in_frame_ref,
  input  logic [7:0]          in_len_bytes,
  input  logic                in_urgent,
  input  logic [1:0]          in_link_status,
  output logic                out_valid,
  output logic                out_accepted,
  output logic                out_evicted_low,
  output logic                out_start_valid,
  output logic [1:0]          out_start_slot,
  output logic [REF_BITS-1:0] out_start_ref,
  output logic [7:0]          out_start_len,
  output logic [2:0]          out_queued,
  output logic [31:0]         out_drop_total,
  output logic [31:0]         out_sent_total
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(SLOTS);
  localparam logic [7:0]    LEN_MAX  = 8'(MAX_FRAME_BYTES);

  ptfq_state_t state_r, state_nxt;

  // Captured transaction.
  ptfq_cmd_t           cmd_r, cmd_nxt;
  logic [REF_BITS-1:0] ref_r, ref_nxt;
  logic [7:0]          len_r, len_nxt;
  logic                urg_r, urg_nxt;
  logic [1:0]          link_r, link_nxt;

  // Slot storage.
  logic [SLOTS-1:0]    used_r, used_nxt;
  logic                urgent_r [SLOTS];
  logic [AGE_BITS-1:0] age_r    [SLOTS];
  logic [REF_BITS-1:0] sref_r   [SLOTS];
  logic [7:0]          slen_r   [SLOTS];
  logic                wr_en;

  logic [CW-1:0]       used_cnt_r, used_cnt_nxt;
  logic                act_valid_r, act_valid_nxt;
  logic [IW-1:0]       act_idx_r, act_idx_nxt;
  logic [AGE_BITS-1:0] next_age_r, next_age_nxt;
  logic [CNT_BITS-1:0] drops_r, drops_nxt;
  logic [CNT_BITS-1:0] sent_r, sent_nxt;

  // Result fields.
  logic                acc_r, acc_nxt;
  logic                evict_r, evict_nxt;
  logic                st_valid_r, st_valid_nxt;
  logic [IW-1:0]       st_idx_r, st_idx_nxt;
  logic [REF_BITS-1:0] st_ref_r, st_ref_nxt;
  logic [7:0]          st_len_r, st_len_nxt;

  // Scan state.
  logic [IW-1:0]       scan_idx_r, scan_idx_nxt;
  logic                best_valid_r, best_valid_nxt;
  logic [IW-1:0]       best_idx_r, best_idx_nxt;
  logic                best_urg_r, best_urg_nxt;
  logic [AGE_BITS-1:0] best_age_r, best_age_nxt;

  logic                len_ok;
  logic                is_full;
  logic                free_found;
  logic [IW-1:0]       free_idx;
  ptfq_cand_t          cand;
  ptfq_cand_t          best;
  logic                better;
  logic                scan_last;
  logic [IW+1:0]       slot_ext;
  logic [CW+2:0]       cnt_ext;

  assign len_ok    = (len_r != 8'd0) && (len_r <= LEN_MAX);
  assign is_full   = (used_cnt_r >= FULL_CNT);
  assign scan_last = (scan_idx_r == LAST_IDX);

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_found = 1'b1;
        free_idx   = IW'(i);
      end
    end
  end

  // The eviction scan skips urgent slots; the start scan looks at all of them.
  always_comb begin
    cand.valid  = used_r[scan_idx_r] &&
                  !(act_valid_r && (act_idx_r == scan_idx_r)) &&
                  !((state_r == ST_EVICT) && urgent_r[scan_idx_r]);
    cand.urgent = urgent_r[scan_idx_r];
    cand.age    = age_r[scan_idx_r];
    best.valid  = best_valid_r;
    best.urgent = best_urg_r;
    best.age    = best_age_r;
  end

  ptfq_age_cmp u_cmp (
    .cand   (cand),
    .best   (best),
    .better (better)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        case (cmd_r)
          CMD_ENQUEUE: begin
            if (!len_ok) begin
              state_nxt = ST_DONE;
            end else if (is_full) begin
              state_nxt = urg_r ? ST_EVICT : ST_DONE;
            end else begin
              state_nxt = ST_STORE;
            end
          end
          CMD_TX_DONE, CMD_LINK_ERR: state_nxt = ST_PICK;
          default:                   state_nxt = ST_DONE;
        endcase
      end
      ST_EVICT: begin
        if (scan_last) begin
          state_nxt = ST_EVICT_END;
        end
      end
      ST_EVICT_END: state_nxt = best_valid_r ? ST_STORE : ST_DONE;
      ST_STORE: begin
        state_nxt = (!free_found || act_valid_r) ? ST_DONE : ST_PICK;
      end
      ST_PICK: begin
        if (scan_last) begin
          state_nxt = ST_PICK_END;
        end
      end
      ST_PICK_END: state_nxt = ST_DONE;
      ST_DONE:     state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Datapath.
  always_comb begin
    cmd_nxt        = cmd_r;
    ref_nxt        = ref_r;
    len_nxt        = len_r;
    urg_nxt        = urg_r;
    link_nxt       = link_r;
    used_nxt       = used_r;
    used_cnt_nxt   = used_cnt_r;
    act_valid_nxt  = act_valid_r;
    act_idx_nxt    = act_idx_r;
    next_age_nxt   = next_age_r;
    drops_nxt      = drops_r;
    sent_nxt       = sent_r;
    acc_nxt        = acc_r;
    evict_nxt      = evict_r;
    st_valid_nxt   = st_valid_r;
    st_idx_nxt     = st_idx_r;
    st_ref_nxt     = st_ref_r;
    st_len_nxt     = st_len_r;
    scan_idx_nxt   = scan_idx_r;
    best_valid_nxt = best_valid_r;
    best_idx_nxt   = best_idx_r;
    best_urg_nxt   = best_urg_r;
    best_age_nxt   = best_age_r;
    wr_en          = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd_nxt  = ptfq_cmd_t'(in_cmd);
          ref_nxt  = in_frame_ref;
          len_nxt  = in_len_bytes;
          urg_nxt  = in_urgent;
          link_nxt = in_link_status;
        end
      end
      ST_DECIDE: begin
        acc_nxt        = 1'b0;
        evict_nxt      = 1'b0;
        st_valid_nxt   = 1'b0;
        st_idx_nxt     = '0;
        st_ref_nxt     = '0;
        st_len_nxt     = '0;
        scan_idx_nxt   = '0;
        best_valid_nxt = 1'b0;
        case (cmd_r)
          CMD_ENQUEUE: begin
            if (len_ok && is_full && !urg_r) begin
              drops_nxt = drops_r + 1'b1;
            end
          end
          CMD_TX_DONE, CMD_LINK_ERR: begin
            if (act_valid_r && used_r[act_idx_r]) begin
              used_nxt[act_idx_r] = 1'b0;
              if (used_cnt_r != '0) begin
                used_cnt_nxt = used_cnt_r - 1'b1;
              end
              if (cmd_r == CMD_TX_DONE) begin
                sent_nxt = sent_r + 1'b1;
              end else begin
                drops_nxt = drops_r + 1'b1;
              end
            end
            act_valid_nxt = 1'b0;
          end
          default: begin
          end
        endcase
      end
      ST_EVICT, ST_PICK: begin
        if (better) begin
          best_valid_nxt = 1'b1;
          best_idx_nxt   = scan_idx_r;
          best_urg_nxt   = cand.urgent;
          best_age_nxt   = cand.age;
        end
        scan_idx_nxt = scan_idx_r + 1'b1;
      end
      ST_EVICT_END: begin
        drops_nxt = drops_r + 1'b1;
        if (best_valid_r) begin
          used_nxt[best_idx_r] = 1'b0;
          if (used_cnt_r != '0) begin
            used_cnt_nxt = used_cnt_r - 1'b1;
          end
          evict_nxt = 1'b1;
        end
      end
      ST_STORE: begin
        scan_idx_nxt   = '0;
        best_valid_nxt = 1'b0;
        if (free_found) begin
          wr_en              = 1'b1;
          used_nxt[free_idx] = 1'b1;
          used_cnt_nxt       = used_cnt_r + 1'b1;
          next_age_nxt       = next_age_r + 1'b1;
          acc_nxt            = 1'b1;
        end else begin
          drops_nxt = drops_r + 1'b1;
        end
      end
      ST_PICK_END: begin
        if (best_valid_r) begin
          if (link_r == LINK_OK) begin
            act_valid_nxt = 1'b1;
            act_idx_nxt   = best_idx_r;
            st_valid_nxt  = 1'b1;
            st_idx_nxt    = best_idx_r;
            st_ref_nxt    = sref_r[best_idx_r];
            st_len_nxt    = slen_r[best_idx_r];
          end else if (link_r != LINK_BUSY) begin
            used_nxt[best_idx_r] = 1'b0;
            if (used_cnt_r != '0) begin
              used_cnt_nxt = used_cnt_r - 1'b1;
            end
            drops_nxt = drops_r + 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_r      <= '0;
      used_cnt_r  <= '0;
      act_valid_r <= 1'b0;
      next_age_r  <= '0;
      drops_r     <= '0;
      sent_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      used_cnt_r  <= used_cnt_nxt;
      act_valid_r <= act_valid_nxt;
      next_age_r  <= next_age_nxt;
      drops_r     <= drops_nxt;
      sent_r      <= sent_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    ref_r        <= ref_nxt;
    len_r        <= len_nxt;
    urg_r        <= urg_nxt;
    link_r       <= link_nxt;
    act_idx_r    <= act_idx_nxt;
    acc_r        <= acc_nxt;
    evict_r      <= evict_nxt;
    st_valid_r   <= st_valid_nxt;
    st_idx_r     <= st_idx_nxt;
    st_ref_r     <= st_ref_nxt;
    st_len_r     <= st_len_nxt;
    scan_idx_r   <= scan_idx_nxt;
    best_valid_r <= best_valid_nxt;
    best_idx_r   <= best_idx_nxt;
    best_urg_r   <= best_urg_nxt;
    best_age_r   <= best_age_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      urgent_r[free_idx] <= urg_r;
      age_r[free_idx]    <= next_age_r;
      sref_r[free_idx]   <= ref_r;
      slen_r[free_idx]   <= len_r;
    end
  end

  // Outputs.
  always_comb begin
    busy            = (state_r != ST_IDLE);
    out_valid       = (state_r == ST_DONE);
    slot_ext        = {2'b00, st_idx_r};
    cnt_ext         = {3'b000, used_cnt_r};
    out_accepted    = acc_r;
    out_evicted_low = evict_r;
    out_start_valid = st_valid_r;
    out_start_slot  = slot_ext[1:0];
    out_start_ref   = st_ref_r;
    out_start_len   = st_len_r;
    out_queued      = cnt_ext[2:0];
    out_drop_total  = drops_r;
    out_sent_total  = sent_r;
  end

endmodule

@@ src/ptfq_age_cmp.sv @@
// Shared compare unit of the slot scans.
// Depends on ptfq_pkg for the candidate type.
module ptfq_age_cmp import ptfq_pkg::*; (
  input  ptfq_cand_t cand,
  input  ptfq_cand_t best,
  output logic       better
);

  // Higher priority wins, then the lower age. Equal ages keep the earlier slot.
  assign better = cand.valid &&
                  (!best.valid ||
                   (cand.urgent && !best.urgent) ||
                   ((cand.urgent == best.urgent) && (cand.age < best.age)));

endmodule

@@ src/ptfq_checker.sv @@
// Port-level checks for the priority transmit frame queue, and the bind that attaches them.
// Sees only the top level's ports; no package dependency.
module ptfq_checker #(
  parameter int REF_BITS = 16
) (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input logic                out_accepted,
  input logic                out_evicted_low,
  input logic                out_start_valid,
  input logic [1:0]          out_start_slot,
  input logic [REF_BITS-1:0] out_start_ref,
  input logic [7:0]          out_start_len
);

  // A result strobe lasts exactly one cycle.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  // An accepted transaction keeps the block busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("block not busy after accepting a transaction");

  // A result only follows work in progress.
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a transaction in progress");

  // An eviction only happens to make room for a stored frame.
  a_evict_implies_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_evicted_low) |-> out_accepted)
    else $error("eviction reported without the frame being accepted");

  // Start fields read zero when no transmission was started.
  a_start_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_start_valid) |->
      ((out_start_slot == 2'd0) && (out_start_ref == '0) && (out_start_len == 8'd0)))
    else $error("start fields not zero without a started transmission");

endmodule

bind priority_tx_frame_queue ptfq_checker #(.REF_BITS(REF_BITS)) u_ptfq_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_accepted    (out_accepted),
  .out_evicted_low (out_evicted_low),
  .out_start_valid (out_start_valid),
  .out_start_slot  (out_start_slot),
  .out_start_ref   (out_start_ref),
  .out_start_len   (out_start_len)
);
